// File: rtl/tcce_pkg.sv
package tcce_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 11;

  localparam logic CMD_PUT   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Kind of work the back end has to do for one word.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_NEWLINE,
    CLS_TAB,
    CLS_PRINT,
    CLS_CLEAR
  } item_class_t;

  typedef struct packed {
    item_class_t       cls;
    logic [CHAR_W-1:0] char_code;
  } item_t;

  typedef struct packed {
    logic              write_valid;
    logic [CELL_W-1:0] write_cell;
    logic [CHAR_W-1:0] write_char;
    logic [ATTR_W-1:0] write_attr;
    logic              scroll_up;
    logic              clear_all;
    logic [CELL_W-1:0] cursor_cell;
  } result_t;

endpackage

// File: rtl/tcce_fifo.sv
module tcce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/tcce_front.sv
module tcce_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] in_char_code,
  output logic                        in_full,
  input  logic                        item_pop,
  output tcce_pkg::item_t             item,
  output logic                        item_empty
);

  tcce_pkg::item_t cls_item;

  // Sort each word into the kind of cursor work it needs.
  always_comb begin
    cls_item.char_code = in_char_code;
    if (in_cmd == tcce_pkg::CMD_CLEAR) begin
      cls_item.cls = tcce_pkg::CLS_CLEAR;
    end else if (in_char_code == tcce_pkg::CHAR_NUL) begin
      cls_item.cls = tcce_pkg::CLS_NONE;
    end else if (in_char_code == tcce_pkg::CHAR_LF || in_char_code == tcce_pkg::CHAR_CR) begin
      cls_item.cls = tcce_pkg::CLS_NEWLINE;
    end else if (in_char_code == tcce_pkg::CHAR_TAB) begin
      cls_item.cls = tcce_pkg::CLS_TAB;
    end else begin
      cls_item.cls = tcce_pkg::CLS_PRINT;
    end
  end

  tcce_fifo #(
    .WIDTH ($bits(tcce_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (cls_item),
    .full    (in_full),
    .pop     (item_pop),
    .rd_data (item),
    .empty   (item_empty)
  );

endmodule

// File: rtl/tcce_back.sv
module tcce_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcce_pkg::item_t             item,
  input  logic                        item_empty,
  output logic                        item_pop,
  input  logic [tcce_pkg::ATTR_W-1:0] text_attr,
  input  logic                        res_full,
  output logic                        res_push,
  output tcce_pkg::result_t           res
);

  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W      = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int PH_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int BASE_W     = ROW_W + COL_W;
  localparam int COLT_W     = $clog2(SCREEN_COLUMNS + TAB_STOP);
  localparam int MAX_WRAPS  = (SCREEN_COLUMNS - 1 + TAB_STOP) / SCREEN_COLUMNS;
  localparam int WRAP_STEP  = SCREEN_COLUMNS % TAB_STOP;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PH_W-1:0]   ph_r, ph_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;

  logic              at_last_row;
  logic              col_last;
  logic [PH_W:0]     ph_inc;
  logic [COLT_W-1:0] tab_sum;
  logic [COLT_W-1:0] tab_col;
  logic [PH_W-1:0]   tab_ph;
  logic              tab_wrap;

  assign item_pop    = !item_empty && !res_full;
  assign res_push    = item_pop;
  assign at_last_row = (row_r == ROW_W'(SCREEN_ROWS - 1));
  assign col_last    = ((COL_W + 1)'(col_r) + 1'b1 == (COL_W + 1)'(SCREEN_COLUMNS));
  assign ph_inc      = (PH_W + 1)'(ph_r) + 1'b1;

  // Tab target column. The sum is a multiple of the tab stop, so its phase is
  // zero; each wrap past the row end shifts the phase by the width remainder.
  always_comb begin
    tab_sum  = COLT_W'(col_r) - COLT_W'(ph_r) + COLT_W'(TAB_STOP);
    tab_wrap = (tab_sum >= COLT_W'(SCREEN_COLUMNS));
    tab_col  = tab_sum;
    tab_ph   = '0;
    for (int k = 0; k < MAX_WRAPS; k++) begin
      if (tab_col >= COLT_W'(SCREEN_COLUMNS)) begin
        tab_col = tab_col - COLT_W'(SCREEN_COLUMNS);
        if (tab_ph >= PH_W'(WRAP_STEP)) begin
          tab_ph = tab_ph - PH_W'(WRAP_STEP);
        end else begin
          tab_ph = PH_W'((PH_W + 1)'(tab_ph) + (PH_W + 1)'(TAB_STOP - WRAP_STEP));
        end
      end
    end
  end

  always_comb begin
    logic advance;
    advance  = 1'b0;
    col_nxt  = col_r;
    ph_nxt   = ph_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    res      = '0;

    unique case (item.cls)
      tcce_pkg::CLS_CLEAR: begin
        res.clear_all  = 1'b1;
        res.write_char = tcce_pkg::CHAR_SPACE;
        res.write_attr = text_attr;
        col_nxt        = '0;
        ph_nxt         = '0;
        row_nxt        = '0;
        base_nxt       = '0;
      end
      tcce_pkg::CLS_NEWLINE: begin
        col_nxt = '0;
        ph_nxt  = '0;
        advance = 1'b1;
      end
      tcce_pkg::CLS_TAB: begin
        if (tab_wrap) begin
          col_nxt = tab_col[COL_W-1:0];
          ph_nxt  = tab_ph;
          advance = 1'b1;
        end else begin
          col_nxt = tab_sum[COL_W-1:0];
          ph_nxt  = '0;
        end
      end
      tcce_pkg::CLS_PRINT: begin
        res.write_valid = 1'b1;
        res.write_cell  = tcce_pkg::CELL_W'((BASE_W + 1)'(base_r) + (BASE_W + 1)'(col_r));
        res.write_char  = item.char_code;
        res.write_attr  = text_attr;
        if (col_last) begin
          col_nxt = '0;
          ph_nxt  = '0;
          advance = 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
          ph_nxt  = (ph_inc == (PH_W + 1)'(TAB_STOP)) ? '0 : ph_inc[PH_W-1:0];
        end
      end
      default: begin
      end
    endcase

    if (advance) begin
      if (at_last_row) begin
        res.scroll_up = 1'b1;
      end else begin
        row_nxt  = row_r + 1'b1;
        base_nxt = base_r + BASE_W'(SCREEN_COLUMNS);
      end
    end

    res.cursor_cell = tcce_pkg::CELL_W'((BASE_W + 1)'(base_nxt) + (BASE_W + 1)'(col_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      ph_r   <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else if (item_pop) begin
      col_r  <= col_nxt;
      ph_r   <= ph_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (COL_W + 1)'(col_r) < (COL_W + 1)'(SCREEN_COLUMNS))
    else $error("cursor column left the screen");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ROW_W + 1)'(row_r) < (ROW_W + 1)'(SCREEN_ROWS))
    else $error("cursor row left the screen");

  a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    (BASE_W + 8)'(base_r) == (BASE_W + 8)'(row_r) * (BASE_W + 8)'(SCREEN_COLUMNS))
    else $error("row base out of step with cursor row");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && item.cls == tcce_pkg::CLS_CLEAR) |=> (col_r == '0 && row_r == '0))
    else $error("clear did not home the cursor");

endmodule

// File: rtl/text_console_cursor_engine_top.sv
// Text console cursor engine.
// Input channel: a word is one character byte (in_char_code) or a clear
// command (in_cmd high). It is taken at a rising edge with in_push high and
// in_full low. Result channel: one result word per input word, in order, on
// the out_ ports while out_empty is low; it is taken with out_pop high.
// Configuration: cfg_wr_en with cfg_wr_data loads the text attribute. The user
// must see that it is changed only while no word is in flight; the block does not enforce it.
// A taken word is registered in the item queue, passes the back end and is
// registered in the output queue before it shows on the result ports. One
// word per cycle is sustained while the receiver keeps popping: the small
// queues on either side of the back end keep both channels streaming.
// When the receiver stalls, results collect in the output queue, then the
// item queue fills and in_full rises; nothing is dropped.
// Synchronous reset homes the cursor to cell 0, empties both queues and sets
// the attribute to 0x07.
// QUEUE_DEPTH and OUT_DEPTH must be at least 2 for full rate.
module text_console_cursor_engine_top #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 4,
  parameter int QUEUE_DEPTH    = 2,
  parameter int OUT_DEPTH      = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] in_char_code,
  // Result channel
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_write_valid,
  output logic [tcce_pkg::CELL_W-1:0] out_write_cell,
  output logic [tcce_pkg::CHAR_W-1:0] out_write_char,
  output logic [tcce_pkg::ATTR_W-1:0] out_write_attr,
  output logic                        out_scroll_up,
  output logic                        out_clear_all,
  output logic [tcce_pkg::CELL_W-1:0] out_cursor_cell,
  // Configuration
  input  logic                        cfg_wr_en,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_wr_data
);

  logic [tcce_pkg::ATTR_W-1:0] text_attr_r;

  tcce_pkg::item_t   item;
  logic              item_empty;
  logic              item_pop;
  tcce_pkg::result_t res;
  logic              res_push;
  logic              res_full;
  tcce_pkg::result_t out_word;

  // The user must see that the attribute register only changes while the engine
  // is idle; the block does not enforce it. The back end reads it directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tcce_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attr_r <= cfg_wr_data;
    end
  end

  // Front end: classifies each word and queues it for the back end.
  tcce_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_cmd       (in_cmd),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .item_pop     (item_pop),
    .item         (item),
    .item_empty   (item_empty)
  );

  // Back end: owns the cursor and builds one result word per item.
  tcce_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TAB_STOP       (TAB_STOP)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .text_attr  (text_attr_r),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // Output queue decouples the back end from a stalling receiver.
  tcce_fifo #(
    .WIDTH ($bits(tcce_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_word),
    .empty   (out_empty)
  );

  assign out_write_valid = out_word.write_valid;
  assign out_write_cell  = out_word.write_cell;
  assign out_write_char  = out_word.write_char;
  assign out_write_attr  = out_word.write_attr;
  assign out_scroll_up   = out_word.scroll_up;
  assign out_clear_all   = out_word.clear_all;
  assign out_cursor_cell = out_word.cursor_cell;

endmodule
